### hw/rtl/motsup_pkg.sv
// Package: shared types, codes and reset values for the lock motor supervisor.
`timescale 1ns / 1ps

package motsup_pkg;

	// Input beat kinds
	localparam logic [1:0] KIND_TICK     = 2'd0;
	localparam logic [1:0] KIND_LOCK_ON  = 2'd1;
	localparam logic [1:0] KIND_LOCK_OFF = 2'd2;
	localparam logic [1:0] KIND_STOP     = 2'd3;

	// Limit switch positions
	localparam logic [1:0] POS_TOP    = 2'd0;
	localparam logic [1:0] POS_BOTTOM = 2'd2;

	// Motor drive codes
	localparam logic [1:0] DIR_OFF  = 2'd0;
	localparam logic [1:0] DIR_UP   = 2'd1;
	localparam logic [1:0] DIR_DOWN = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] REG_UP_STOP_CURRENT   = 2'd0;
	localparam logic [1:0] REG_DOWN_STOP_CURRENT = 2'd1;
	localparam logic [1:0] REG_SAMPLE_PERIOD     = 2'd2;
	localparam logic [1:0] REG_MOVE_TIMEOUT      = 2'd3;

	// Configuration reset values
	localparam logic [15:0] UP_STOP_CURRENT_RST   = 16'd2000;
	localparam logic [15:0] DOWN_STOP_CURRENT_RST = 16'd2000;
	localparam logic [15:0] SAMPLE_PERIOD_RST     = 16'd200;
	localparam logic [15:0] MOVE_TIMEOUT_RST      = 16'd5000;

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  position;
		logic [15:0] current_ma;
	} in_beat_t;

	typedef struct packed {
		logic [1:0] motor_drive;
		logic       sensing_on;
		logic       buzzer_pulse;
		logic       up_fault;
		logic       down_fault;
	} out_beat_t;

	typedef struct packed {
		logic [15:0] up_stop_current;
		logic [15:0] down_stop_current;
		logic [15:0] sample_period_ticks;
		logic [15:0] move_timeout_ticks;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  motor_dir;
		logic        running;
		logic [15:0] sample_count;
		logic [15:0] timeout_count;
		logic        up_fault_flag;
		logic        down_fault_flag;
	} sup_state_t;

endpackage

### hw/rtl/motsup_step.sv
// Next-state and result logic for one supervisor beat.
`timescale 1ns / 1ps

module motsup_step (
	input  motsup_pkg::sup_state_t cur,
	input  motsup_pkg::cfg_t       cfg,
	input  motsup_pkg::in_beat_t   beat,
	output motsup_pkg::sup_state_t nxt,
	output motsup_pkg::out_beat_t  res
);
	import motsup_pkg::*;

	logic [15:0] smp_inc;
	logic [15:0] tmo_inc;
	logic        smp_hit;
	logic        tmo_hit;
	logic        buzz;

	// Counter increments and expiry compares (zero period acts as one)
	assign smp_inc = cur.sample_count + 16'd1;
	assign tmo_inc = cur.timeout_count + 16'd1;
	assign smp_hit = (smp_inc >= cfg.sample_period_ticks) || (smp_inc == 16'd0);
	assign tmo_hit = (tmo_inc >= cfg.move_timeout_ticks) || (tmo_inc == 16'd0);

	// Command decode and tick handling
	always_comb begin
		nxt  = cur;
		buzz = 1'b0;
		case (beat.kind)
			KIND_LOCK_ON: begin
				if (beat.position != POS_TOP) begin
					if (!cur.running) begin
						nxt.running       = 1'b1;
						nxt.sample_count  = '0;
						nxt.timeout_count = '0;
					end
					nxt.motor_dir = DIR_UP;
				end
			end
			KIND_LOCK_OFF: begin
				if (beat.position != POS_BOTTOM) begin
					if (!cur.running) begin
						nxt.running       = 1'b1;
						nxt.sample_count  = '0;
						nxt.timeout_count = '0;
					end
					nxt.motor_dir = DIR_DOWN;
				end
			end
			KIND_STOP: begin
				nxt.running       = 1'b0;
				nxt.sample_count  = '0;
				nxt.timeout_count = '0;
				nxt.motor_dir     = DIR_OFF;
			end
			default: begin
				if (cur.running) begin
					nxt.sample_count = smp_inc;
					if (smp_hit) begin
						nxt.sample_count = '0;
						if (cur.motor_dir == DIR_UP &&
						    beat.current_ma >= cfg.up_stop_current) begin
							nxt.up_fault_flag = 1'b1;
							nxt.motor_dir     = DIR_DOWN;
						end else if (cur.motor_dir == DIR_DOWN &&
						             beat.current_ma >= cfg.down_stop_current) begin
							nxt.running         = 1'b0;
							nxt.motor_dir       = DIR_OFF;
							nxt.down_fault_flag = 1'b1;
						end
					end
					// timeout is skipped when the current check already stopped
					if (nxt.running) begin
						nxt.timeout_count = tmo_inc;
						if (tmo_hit) begin
							buzz          = 1'b1;
							nxt.running   = 1'b0;
							nxt.motor_dir = DIR_OFF;
						end
					end
					if (!nxt.running) begin
						nxt.sample_count  = '0;
						nxt.timeout_count = '0;
					end
				end
			end
		endcase
	end

	// Result beat from the updated state
	assign res.motor_drive  = nxt.motor_dir;
	assign res.sensing_on   = nxt.running;
	assign res.buzzer_pulse = buzz;
	assign res.up_fault     = nxt.up_fault_flag;
	assign res.down_fault   = nxt.down_fault_flag;

endmodule

### hw/rtl/motor_overcurrent_timeout_supervisor_core.sv
// Top level: lock motor supervisor with input register, state and result register.
// Path: input register, step logic, then result register driving out_data.
// Throughput: one beat per cycle unless a full result slot stalls on out_ready;
// the single-pass step logic sets this, with state updated every beat.
// Reset (arst_n low, async): motor off, counters and fault flags cleared,
// thresholds and periods back to their defaults, both pipeline slots empty.
`timescale 1ns / 1ps

module motor_overcurrent_timeout_supervisor_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  motsup_pkg::in_beat_t  in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output motsup_pkg::out_beat_t out_data,
	input  logic                  cfg_wr_en,
	input  logic [1:0]            cfg_addr,
	input  logic [15:0]           cfg_wdata
);
	import motsup_pkg::*;

	cfg_t       cfg_q;
	sup_state_t state_q;
	sup_state_t state_nxt;
	in_beat_t   beat_s1;
	logic       valid_s1;
	out_beat_t  res_nxt;
	out_beat_t  res_q;
	logic       res_valid_q;
	logic       adv_s1;

	// Handshake: stage 1 moves when the result slot is free or being drained
	assign adv_s1   = valid_s1 && (!res_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.up_stop_current     <= UP_STOP_CURRENT_RST;
			cfg_q.down_stop_current   <= DOWN_STOP_CURRENT_RST;
			cfg_q.sample_period_ticks <= SAMPLE_PERIOD_RST;
			cfg_q.move_timeout_ticks  <= MOVE_TIMEOUT_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				REG_UP_STOP_CURRENT:   cfg_q.up_stop_current     <= cfg_wdata;
				REG_DOWN_STOP_CURRENT: cfg_q.down_stop_current   <= cfg_wdata;
				REG_SAMPLE_PERIOD:     cfg_q.sample_period_ticks <= cfg_wdata;
				REG_MOVE_TIMEOUT:      cfg_q.move_timeout_ticks  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Input register payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			beat_s1 <= in_data;
		end
	end

	// Per-beat step logic
	motsup_step u_step (
		.cur  (state_q),
		.cfg  (cfg_q),
		.beat (beat_s1),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	// Supervisor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.motor_dir       <= DIR_OFF;
			state_q.running         <= 1'b0;
			state_q.sample_count    <= '0;
			state_q.timeout_count   <= '0;
			state_q.up_fault_flag   <= 1'b0;
			state_q.down_fault_flag <= 1'b0;
		end else if (adv_s1) begin
			state_q <= state_nxt;
		end
	end

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv_s1) begin
			res_valid_q <= 1'b1;
		end else if (out_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid = res_valid_q;
	assign out_data  = res_q;

endmodule
